// ===== rtl/core/nocc_pkg.sv =====
// ----------------------------------------------------------------------------
// nocc_pkg
// Shared types and constants of the row-splits to COO coordinate converter.
// ----------------------------------------------------------------------------
`default_nettype none

package nocc_pkg;

  localparam int unsigned MaxLevels  = 4;
  localparam int unsigned MaxSplits  = 1024;
  localparam int unsigned LvlW       = 2;
  localparam int unsigned PosW       = 10;
  localparam int unsigned CntW       = 11;
  localparam int unsigned ValW       = 32;
  localparam int unsigned NlW        = 3;
  localparam int unsigned AddrW      = LvlW + PosW;
  localparam int unsigned Depth      = MaxLevels * MaxSplits;
  localparam int unsigned InDataW    = 48;
  localparam int unsigned OutDataW   = 40;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_LEAF   = 2'd1,
    OP_EXTENT = 2'd2
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [LvlW-1:0]     level;
    logic [PosW-1:0]     pos;
    logic [ValW-1:0]     value;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/nocc_ram.sv =====
// ----------------------------------------------------------------------------
// nocc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nocc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/nocc_front.sv =====
// ----------------------------------------------------------------------------
// nocc_front
// Input side: accepts transfers, drops unknown operations, queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module nocc_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [nocc_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  wire logic [1:0]                    s_axis_tuser_i,
  output logic                               cmd_valid_o,
  output nocc_pkg::cmd_t                     cmd_o,
  input  wire logic                          cmd_pop_i
);
  import nocc_pkg::*;

  cmd_t       q_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       known, push, acc;
  cmd_t       cmd_in;

  assign acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign known = (s_axis_tuser_i == OP_LOAD) || (s_axis_tuser_i == OP_LEAF) ||
                 (s_axis_tuser_i == OP_EXTENT);
  assign push  = acc && known;

  always_comb begin
    cmd_in.op    = op_e'(s_axis_tuser_i);
    cmd_in.level = s_axis_tdata_i[1:0];
    cmd_in.pos   = s_axis_tdata_i[11:2];
    cmd_in.value = s_axis_tdata_i[43:12];
  end

  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign cmd_valid_o     = (cnt_q != 2'd0);
  assign cmd_o           = q_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = cmd_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cnt_q != 2'd0) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 && !cmd_pop_i |=> cnt_q == 2'd2) else $error("queue overrun");

endmodule

`default_nettype wire

// ===== rtl/core/nocc_back.sv =====
// ----------------------------------------------------------------------------
// nocc_back
// Execution side: split store, level cursors, leaf walk, extents, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module nocc_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [nocc_pkg::NlW-1:0]      num_levels_i,
  input  wire logic                          cmd_valid_i,
  input  wire nocc_pkg::cmd_t                cmd_i,
  output logic                               cmd_pop_o,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [nocc_pkg::OutDataW-1:0]      m_axis_tdata_o,
  output logic                               m_axis_tlast_o
);
  import nocc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LSTRT = 4'd1;
  localparam logic [3:0] S_LBASE = 4'd2;
  localparam logic [3:0] S_LBEG  = 4'd3;
  localparam logic [3:0] S_LEND  = 4'd4;
  localparam logic [3:0] S_LEMIT = 4'd5;
  localparam logic [3:0] S_ESTRT = 4'd6;
  localparam logic [3:0] S_EPREV = 4'd7;
  localparam logic [3:0] S_ENEXT = 4'd8;
  localparam logic [3:0] S_EEMIT = 4'd9;

  logic [3:0]      st_q, st_d;
  logic [CntW-1:0] cnt_q [MaxLevels];
  logic [CntW-1:0] cnt_d [MaxLevels];
  logic [PosW-1:0] csr_q [MaxLevels];
  logic [PosW-1:0] csr_d [MaxLevels];
  logic [LvlW-1:0] lvl_q, lvl_d, top_lvl;
  logic [PosW-1:0] c_q, c_d;
  logic [ValW-1:0] cur_q, cur_d, base_q, base_d, beg_q, beg_d, best_q, best_d;
  logic            ov_q, ov_d, ol_q, ol_d;
  logic [LvlW-1:0] olvl_q, olvl_d;
  logic [ValW-1:0] oval_q, oval_d;

  logic            we;
  logic [PosW-1:0] rd_pos;
  logic [ValW-1:0] rdata;
  logic [CntW-1:0] n;
  logic [CntW:0]   c_ext, n_ext;
  logic [ValW-1:0] rel_beg, rel_end, len;
  logic            can_emit, in_rng;

  nocc_ram #(.Width(ValW), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i ({cmd_i.level, cmd_i.pos}),
    .wdata_i (cmd_i.value),
    .raddr_i ({lvl_q, rd_pos}),
    .rdata_o (rdata)
  );

  always_comb begin
    if (num_levels_i == 3'd0) begin
      top_lvl = 2'd0;
    end else if (num_levels_i > 3'd4) begin
      top_lvl = 2'd3;
    end else begin
      top_lvl = LvlW'(num_levels_i - 3'd1);
    end
  end

  assign n        = cnt_q[lvl_q];
  assign c_ext    = {2'b00, c_q};
  assign n_ext    = {1'b0, n};
  assign rel_beg  = beg_q - base_q;
  assign rel_end  = rdata - base_q;
  assign in_rng   = (cur_q >= rel_beg) && (cur_q < rel_end);
  assign len      = rdata - base_q;
  assign can_emit = !ov_q || m_axis_tready_i;

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    csr_d  = csr_q;
    lvl_d  = lvl_q;
    c_d    = c_q;
    cur_d  = cur_q;
    base_d = base_q;
    beg_d  = beg_q;
    best_d = best_q;
    ov_d   = ov_q && !m_axis_tready_i;
    ol_d   = ol_q;
    olvl_d = olvl_q;
    oval_d = oval_q;
    we     = 1'b0;
    rd_pos = '0;
    cmd_pop_o = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            OP_LOAD: begin
              we = 1'b1;
              cnt_d[cmd_i.level] = {1'b0, cmd_i.pos} + CntW'(1);
              for (int i = 0; i < MaxLevels; i++) begin
                csr_d[i] = '0;
              end
            end
            OP_LEAF: begin
              cur_d = cmd_i.value;
              lvl_d = top_lvl;
              st_d  = S_LSTRT;
            end
            OP_EXTENT: begin
              lvl_d = '0;
              st_d  = S_ESTRT;
            end
            default: begin
            end
          endcase
        end
      end
      S_LSTRT: begin
        if (n == '0) begin
          c_d    = csr_q[lvl_q];
          base_d = '0;
          beg_d  = '0;
          st_d   = S_LEMIT;
        end else begin
          c_d    = ({2'b00, csr_q[lvl_q]} > n_ext - 12'd1) ?
                   PosW'(n - CntW'(1)) : csr_q[lvl_q];
          rd_pos = '0;
          st_d   = S_LBASE;
        end
      end
      S_LBASE: begin
        base_d = rdata;
        rd_pos = c_q;
        st_d   = S_LBEG;
      end
      S_LBEG: begin
        beg_d = rdata;
        if (c_ext + 12'd1 < n_ext) begin
          rd_pos = c_q + PosW'(1);
          st_d   = S_LEND;
        end else begin
          st_d = S_LEMIT;
        end
      end
      S_LEND: begin
        if (in_rng) begin
          st_d = S_LEMIT;
        end else begin
          c_d   = c_q + PosW'(1);
          beg_d = rdata;
          if (c_ext + 12'd2 < n_ext) begin
            rd_pos = c_q + PosW'(2);
          end else begin
            st_d = S_LEMIT;
          end
        end
      end
      S_LEMIT: begin
        if (can_emit) begin
          ov_d          = 1'b1;
          olvl_d        = lvl_q;
          oval_d        = cur_q - rel_beg;
          ol_d          = (lvl_q == '0);
          csr_d[lvl_q]  = c_q;
          cur_d         = {{(ValW-PosW){1'b0}}, c_q};
          if (lvl_q == '0) begin
            st_d = S_IDLE;
          end else begin
            lvl_d = lvl_q - LvlW'(1);
            st_d  = S_LSTRT;
          end
        end
      end
      S_ESTRT: begin
        best_d = '0;
        if (n < CntW'(2)) begin
          st_d = S_EEMIT;
        end else begin
          rd_pos = '0;
          st_d   = S_EPREV;
        end
      end
      S_EPREV: begin
        base_d = rdata;
        rd_pos = PosW'(1);
        c_d    = PosW'(1);
        st_d   = S_ENEXT;
      end
      S_ENEXT: begin
        if (len > best_q) begin
          best_d = len;
        end
        base_d = rdata;
        if (c_ext + 12'd1 < n_ext) begin
          rd_pos = c_q + PosW'(1);
          c_d    = c_q + PosW'(1);
        end else begin
          st_d = S_EEMIT;
        end
      end
      S_EEMIT: begin
        if (can_emit) begin
          ov_d   = 1'b1;
          olvl_d = lvl_q;
          oval_d = best_q;
          ol_d   = (lvl_q == top_lvl);
          if (lvl_q == top_lvl) begin
            st_d = S_IDLE;
          end else begin
            lvl_d = lvl_q + LvlW'(1);
            st_d  = S_ESTRT;
          end
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    cur_q  <= cur_d;
    base_q <= base_d;
    beg_q  <= beg_d;
    best_q <= best_d;
    ol_q   <= ol_d;
    olvl_q <= olvl_d;
    oval_q <= oval_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      lvl_q <= '0;
      ov_q  <= 1'b0;
      for (int i = 0; i < MaxLevels; i++) begin
        cnt_q[i] <= '0;
        csr_q[i] <= '0;
      end
    end else begin
      st_q  <= st_d;
      lvl_q <= lvl_d;
      ov_q  <= ov_d;
      cnt_q <= cnt_d;
      csr_q <= csr_d;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tlast_o  = ol_q;
  assign m_axis_tdata_o  = {6'b0, oval_q, olvl_q};

  a_end_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_LEND |-> c_ext + 12'd1 < n_ext) else $error("walk past last split");
  a_ext_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_ENEXT |-> c_ext < n_ext) else $error("extent index past count");
  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[lvl_q] != '0 |-> {1'b0, csr_q[lvl_q]} < cnt_q[lvl_q])
    else $error("cursor beyond split count");

endmodule

`default_nettype wire

// ===== rtl/core/nested_offsets_to_coo_coords_core.sv =====
// ----------------------------------------------------------------------------
// nested_offsets_to_coo_coords_core
// Row-splits to COO coordinate converter, top level.
//
// Input stream: tuser carries the operation (load split, convert leaf, emit
// extents); tdata carries level, position and value. Loads produce no output.
// A leaf produces one coordinate per level in use, innermost first; extents
// produce one maximum length per level, level 0 first. tlast marks the final
// transfer of each item. cfg_we_i writes the number of levels in use.
// A two-entry command queue decouples input acceptance from execution.
// Per level, a leaf steps through start, base read, begin read, end read
// (again per cursor advance) and emit; with one split the end read is skipped,
// with none every read. Extents read each split of a level in turn, none with
// fewer than two. The split memory has a single registered read port.
// Reset clears the split counts, cursors and queue; the level count resets to
// 1. Split memory contents are undefined until loaded. When the receiver
// stalls the output register holds, the engine waits, and the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module nested_offsets_to_coo_coords_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [nocc_pkg::NlW-1:0]      cfg_wdata_i,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [1:0] level, [11:2] position, [43:12] value, [47:44] zero
  input  wire logic [nocc_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [1:0] operation
  input  wire logic [1:0]                    s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [1:0] out_level, [33:2] out_value, [39:34] zero
  output logic [nocc_pkg::OutDataW-1:0]      m_axis_tdata_o,
  output logic                               m_axis_tlast_o
);
  import nocc_pkg::*;

  logic [NlW-1:0] nl_q;
  logic           cmd_valid, cmd_pop;
  cmd_t           cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nl_q <= NlW'(1);
    end else if (cfg_we_i) begin
      nl_q <= cfg_wdata_i;
    end
  end

  nocc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  nocc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .num_levels_i    (nl_q),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
